FILE: hw/rtl/mkh_pkg.sv
package mkh_pkg;

	localparam logic [31:0] SEED_INIT   = 32'd5381;
	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;

	localparam logic [15:0] BUCKET_RESET = 16'd1024;
	localparam int unsigned MOD_STEPS    = 32;
	localparam int unsigned CNT_W        = $clog2(MOD_STEPS);

	typedef logic [3:0] step_t;

	// Program addresses
	localparam step_t ST_ACCEPT = 4'd0;
	localparam step_t ST_TAIL   = 4'd1;
	localparam step_t ST_MIX1   = 4'd2;
	localparam step_t ST_MIX2   = 4'd3;
	localparam step_t ST_MIX3   = 4'd4;
	localparam step_t ST_FIN1   = 4'd5;
	localparam step_t ST_FIN2   = 4'd6;
	localparam step_t ST_MOD    = 4'd7;
	localparam step_t ST_EMIT   = 4'd8;

	typedef enum logic [3:0] {
		OP_ACCEPT,
		OP_TAIL,
		OP_MIX1,
		OP_MIX2,
		OP_MIX3,
		OP_FIN1,
		OP_FIN2,
		OP_MOD,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		CND_NEXT,      // fall through
		CND_JUMP,      // unconditional jump to target
		CND_DISPATCH,  // wait for input, then branch on word class
		CND_MORE,      // jump to target when the key continues
		CND_LOOP,      // jump to target until the remainder count wraps
		CND_WAIT_OUT   // hold until the output register is free, then jump
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	function automatic uword_t ucode_rom(input step_t addr);
		uword_t w;
		case (addr)
			ST_ACCEPT: w = '{op: OP_ACCEPT, cond: CND_DISPATCH, target: ST_ACCEPT};
			ST_TAIL:   w = '{op: OP_TAIL,   cond: CND_JUMP,     target: ST_FIN1};
			ST_MIX1:   w = '{op: OP_MIX1,   cond: CND_NEXT,     target: ST_MIX2};
			ST_MIX2:   w = '{op: OP_MIX2,   cond: CND_NEXT,     target: ST_MIX3};
			ST_MIX3:   w = '{op: OP_MIX3,   cond: CND_MORE,     target: ST_ACCEPT};
			ST_FIN1:   w = '{op: OP_FIN1,   cond: CND_NEXT,     target: ST_FIN2};
			ST_FIN2:   w = '{op: OP_FIN2,   cond: CND_NEXT,     target: ST_MOD};
			ST_MOD:    w = '{op: OP_MOD,    cond: CND_LOOP,     target: ST_MOD};
			ST_EMIT:   w = '{op: OP_EMIT,   cond: CND_WAIT_OUT, target: ST_ACCEPT};
			default:   w = '{op: OP_ACCEPT, cond: CND_JUMP,     target: ST_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/murmur2_key_hash.sv
// MurmurHash2 (seed 5381) key hasher with bucket index, driven by a microcoded sequencer.
// Sequencing: a non-last word takes accept plus three passes through the shared
// 32x32 multiplier; a last item takes the mix with a full word, the tail step with tail
// bytes or neither when empty, then the avalanche, bit-serial remainder and emit.
// out_valid is registered at emit; a held result stalls emit, and input stalls until accept.
// Reset (arst_n low, asynchronous): accept step, no result pending, new key next, 1024 buckets.
module murmur2_key_hash
	import mkh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] key_word,
	input  logic [2:0]  valid_bytes,
	input  logic [31:0] total_length,
	input  logic        last_word,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value,
	output logic [15:0] bucket_index
);

	step_t              step_q;
	step_t              step_d;
	uword_t             uw;
	logic               at_start_q;
	logic               last_q;
	logic [31:0]        h_q;
	logic [31:0]        k_q;
	logic [15:0]        rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [15:0]        bucket_count_q;
	logic               out_valid_q;
	logic [31:0]        hash_q;
	logic [15:0]        index_q;

	logic               in_take;
	logic               out_free;
	logic               full_word;
	logic               has_tail;
	logic [31:0]        key_masked;
	logic [31:0]        mul_a;
	logic [31:0]        product;
	logic [16:0]        trial;
	logic [16:0]        trial_sub;

	assign uw       = ucode_rom(step_q);
	assign in_stall = (uw.op != OP_ACCEPT);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign hash_value   = hash_q;
	assign bucket_index = index_q;

	assign full_word = !last_word || (valid_bytes >= 3'd4);
	assign has_tail  = last_word && (valid_bytes != 3'd0) && (valid_bytes < 3'd4);

	always_comb begin
		case (valid_bytes)
			3'd1:    key_masked = {24'd0, key_word[7:0]};
			3'd2:    key_masked = {16'd0, key_word[15:0]};
			3'd3:    key_masked = {8'd0, key_word[23:0]};
			default: key_masked = key_word;
		endcase
	end

	// Operand select for the shared multiplier
	always_comb begin
		case (uw.op)
			OP_MIX1: mul_a = k_q;
			OP_MIX2: mul_a = k_q ^ (k_q >> MIX_SHIFT);
			OP_MIX3: mul_a = h_q;
			OP_TAIL: mul_a = h_q ^ k_q;
			OP_FIN1: mul_a = h_q ^ (h_q >> FIN_SHIFT_A);
			default: mul_a = h_q;
		endcase
	end

	assign product = mul_a * MIX_MUL;

	assign trial     = {rem_q, k_q[31]};
	assign trial_sub = trial - {1'b0, bucket_count_q};

	// Sequencer next step
	always_comb begin
		step_d = step_q + 4'd1;
		case (uw.cond)
			CND_NEXT:     step_d = step_q + 4'd1;
			CND_JUMP:     step_d = uw.target;
			CND_DISPATCH: begin
				if (!in_valid)
					step_d = step_q;
				else if (full_word)
					step_d = ST_MIX1;
				else if (has_tail)
					step_d = ST_TAIL;
				else
					step_d = ST_FIN1;
			end
			CND_MORE:     step_d = last_q ? step_q + 4'd1 : uw.target;
			CND_LOOP:     step_d = (cnt_q != CNT_W'(MOD_STEPS - 1)) ? uw.target : step_q + 4'd1;
			CND_WAIT_OUT: step_d = out_free ? uw.target : step_q;
			default:      step_d = ST_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= ST_ACCEPT;
			at_start_q     <= 1'b1;
			out_valid_q    <= 1'b0;
			bucket_count_q <= BUCKET_RESET;
		end else begin
			step_q <= step_d;
			if (cfg_wr_en)
				bucket_count_q <= cfg_wr_data;
			if (in_take)
				at_start_q <= 1'b0;
			if (uw.op == OP_EMIT && out_free) begin
				at_start_q  <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_ACCEPT: begin
				if (in_valid) begin
					last_q <= last_word;
					k_q    <= full_word ? key_word : key_masked;
					if (at_start_q)
						h_q <= SEED_INIT ^ total_length;
				end
			end
			OP_TAIL: h_q <= product;
			OP_MIX1: k_q <= product;
			OP_MIX2: k_q <= product;
			OP_MIX3: h_q <= product ^ k_q;
			OP_FIN1: h_q <= product;
			OP_FIN2: begin
				h_q   <= h_q ^ (h_q >> FIN_SHIFT_B);
				k_q   <= h_q ^ (h_q >> FIN_SHIFT_B);
				rem_q <= '0;
				cnt_q <= '0;
			end
			OP_MOD: begin
				// restoring remainder, one dividend bit per cycle, msb first
				rem_q <= trial_sub[16] ? trial[15:0] : trial_sub[15:0];
				k_q   <= {k_q[30:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_EMIT: begin
				if (out_free) begin
					hash_q  <= h_q;
					index_q <= (bucket_count_q == 16'd0) ? 16'd0 : rem_q;
				end
			end
			default: ;
		endcase
	end

endmodule
